### src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the RPN stack evaluator: item kinds, status
// codes and the request/response bundles of the iterative arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int XLEN      = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 11;
  localparam int CNT_W     = $clog2(XLEN);

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [XLEN-1:0]     word_t;
  typedef logic [1:0]          alu_op_t;

  // item kinds
  localparam kind_t KIND_PUSH = 3'd0;
  localparam kind_t KIND_ADD  = 3'd1;
  localparam kind_t KIND_SUB  = 3'd2;
  localparam kind_t KIND_MUL  = 3'd3;
  localparam kind_t KIND_DIV  = 3'd4;
  localparam kind_t KIND_POP  = 3'd5;

  // result status
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_DIVZERO = 2'd3;

  // arithmetic unit operations
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_MUL = 2'd2;
  localparam alu_op_t ALU_DIV = 2'd3;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

### src/rpn_if.sv
// ----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels of the RPN evaluator: item in, result out.
// ----------------------------------------------------------------------------
interface rpn_in_if import rpn_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic signed [31:0] operand_value;

  modport source (output valid, output kind, output operand_value, input ready);
  modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface rpn_out_if import rpn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic signed [31:0]   top_value;
  logic [ENTRIES_W-1:0] entries_held;

  modport source (output valid, output status, output top_value, output entries_held,
                  input ready);
  modport sink   (input valid, input status, input top_value, input entries_held,
                  output ready);
endinterface

### src/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative arithmetic unit around one 33-bit adder: add/sub in one pass,
// shift-add multiply over 32 steps, restoring signed divide over 32 steps.
// ----------------------------------------------------------------------------
module rpn_alu import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  word_t    a,
  input  word_t    b,
  output alu_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_ADD  = 3'd1;
  localparam logic [2:0] A_MUL  = 3'd2;
  localparam logic [2:0] A_ABSA = 3'd3;
  localparam logic [2:0] A_ABSB = 3'd4;
  localparam logic [2:0] A_DIV  = 3'd5;
  localparam logic [2:0] A_NEG  = 3'd6;
  localparam logic [2:0] A_DONE = 3'd7;

  logic [2:0]       st_r, st_nxt;
  word_t            x_r, x_nxt;   // accumulator / remainder / result
  word_t            y_r, y_nxt;   // multiplicand / divisor
  word_t            z_r, z_nxt;   // multiplier / dividend-quotient
  alu_op_t          op_r, op_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // the shared adder
  logic [XLEN:0]   opx, opy;
  logic            sub;
  logic [XLEN+1:0] sum;

  assign sum = {1'b0, opx} + {1'b0, (sub ? ~opy : opy)} + {{(XLEN+1){1'b0}}, sub};

  always_comb begin
    st_nxt  = st_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    op_nxt  = op_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    opx     = '0;
    opy     = '0;
    sub     = 1'b0;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          cnt_nxt = '0;
          unique case (req.op)
            ALU_MUL: begin
              x_nxt  = '0;
              y_nxt  = a;
              z_nxt  = b;
              st_nxt = A_MUL;
            end
            ALU_DIV: begin
              z_nxt   = a;
              y_nxt   = b;
              neg_nxt = a[XLEN-1] ^ b[XLEN-1];
              st_nxt  = A_ABSA;
            end
            default: begin
              x_nxt  = a;
              y_nxt  = b;
              st_nxt = A_ADD;
            end
          endcase
        end
      end
      A_ADD: begin
        opx    = {1'b0, x_r};
        opy    = {1'b0, y_r};
        sub    = (op_r == ALU_SUB);
        x_nxt  = sum[XLEN-1:0];
        st_nxt = A_DONE;
      end
      A_MUL: begin
        opx = {1'b0, x_r};
        opy = {1'b0, y_r};
        if (z_r[0]) begin
          x_nxt = sum[XLEN-1:0];
        end
        y_nxt   = {y_r[XLEN-2:0], 1'b0};
        z_nxt   = {1'b0, z_r[XLEN-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          st_nxt = A_DONE;
        end
      end
      A_ABSA: begin
        opy = {1'b0, z_r};
        sub = 1'b1;
        if (z_r[XLEN-1]) begin
          z_nxt = sum[XLEN-1:0];
        end
        st_nxt = A_ABSB;
      end
      A_ABSB: begin
        opy = {1'b0, y_r};
        sub = 1'b1;
        if (y_r[XLEN-1]) begin
          y_nxt = sum[XLEN-1:0];
        end
        x_nxt  = '0;
        st_nxt = A_DIV;
      end
      A_DIV: begin
        // remainder stays below the divisor, so its top bit is always clear
        opx = {x_r, z_r[XLEN-1]};
        opy = {1'b0, y_r};
        sub = 1'b1;
        if (sum[XLEN+1]) begin
          x_nxt = sum[XLEN-1:0];
          z_nxt = {z_r[XLEN-2:0], 1'b1};
        end else begin
          x_nxt = {x_r[XLEN-2:0], z_r[XLEN-1]};
          z_nxt = {z_r[XLEN-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) begin
          st_nxt = A_NEG;
        end
      end
      A_NEG: begin
        opy    = {1'b0, z_r};
        sub    = 1'b1;
        x_nxt  = neg_r ? sum[XLEN-1:0] : z_r;
        st_nxt = A_DONE;
      end
      A_DONE: begin
        st_nxt = A_IDLE;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = (st_r == A_DONE);
  assign rsp.result = x_r;

endmodule

### src/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator for 32-bit signed integers on a RAM stack.
// ----------------------------------------------------------------------------
// in_ch  : one transaction per item: kind (push, add, sub, mul, div, pop final
//          result) and operand_value (used by push only).
// out_ch : one transaction per item: status, top_value (zero on any error) and
//          entries_held (stack depth after the item).
// An item is taken only while the sequencer is idle. Its result goes to an
// output register; a stalled receiver holds that result, the next item runs
// and then waits in the emit step until out_ch drains.
// Steps per item with the receiver ready: push, unused kinds and an operator
// or pop on an empty stack go through exec and emit; pop and errors found on
// the right operand add the right-operand read; add/sub, multiply and divide
// add the left-operand read and the wait on rpn_alu (one bit per cycle through
// its shared adder for multiply and divide, plus one registered RAM read per
// operand). Reset: synchronous, active low. Depth clears, out_ch empties, the RAM
// keeps its contents (only entries below the depth are read); ready right after.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an item
  localparam logic [2:0] S_EXEC = 3'd1;  // decode, push, or read the top entry
  localparam logic [2:0] S_RDB  = 3'd2;  // right operand (or final result) back
  localparam logic [2:0] S_RDA  = 3'd3;  // left operand back, start the unit
  localparam logic [2:0] S_ALU  = 3'd4;  // wait for the unit, push the result
  localparam logic [2:0] S_EMIT = 3'd5;  // park the result in the output reg

  logic [2:0]    st_r, st_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] depth_dec;

  // captured item
  kind_t kind_r;
  word_t value_r;
  word_t b_r, b_nxt;

  // pending result
  status_t res_status_r, res_status_nxt;
  word_t   res_value_r, res_value_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  word_t                out_value_r;
  logic [ENTRIES_W-1:0] out_held_r;
  logic                 slot_free;
  logic [DW+ENTRIES_W-1:0] held_ext;

  // stack RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  word_t         ram_wdata, ram_rdata;

  // arithmetic unit
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  alu_op_t  alu_op;

  logic in_fire;
  logic is_full;
  logic is_empty;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign slot_free   = ~out_valid_r | out_ch.ready;
  assign depth_dec   = depth_r - DW'(1);
  assign is_full     = (depth_r >= DW'(STACK_DEPTH));
  assign is_empty    = (depth_r == '0);

  always_comb begin
    case (kind_r)
      KIND_SUB: alu_op = ALU_SUB;
      KIND_MUL: alu_op = ALU_MUL;
      KIND_DIV: alu_op = ALU_DIV;
      default:  alu_op = ALU_ADD;
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    depth_nxt      = depth_r;
    b_nxt          = b_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = depth_r[AW-1:0];
    ram_wdata      = value_r;
    ram_raddr      = depth_dec[AW-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = alu_op;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt         = S_EMIT;
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        case (kind_r) inside
          KIND_PUSH: begin
            if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we        = 1'b1;
              depth_nxt     = depth_r + DW'(1);
              res_value_nxt = value_r;
            end
          end
          KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_POP: begin
            if (is_empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              // read the top entry, it stays removed whatever follows
              depth_nxt = depth_dec;
              st_nxt    = S_RDB;
            end
          end
          default: ;  // unused kinds answer ok with zero
        endcase
      end
      S_RDB: begin
        b_nxt          = ram_rdata;
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        st_nxt         = S_EMIT;
        if (kind_r == KIND_POP) begin
          res_value_nxt = ram_rdata;
        end else if (kind_r == KIND_DIV && ram_rdata == '0) begin
          // zero divisor is checked before the left operand is looked at
          res_status_nxt = ST_DIVZERO;
        end else if (is_empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          depth_nxt = depth_dec;
          st_nxt    = S_RDA;
        end
      end
      S_RDA: begin
        alu_req.start = 1'b1;
        st_nxt        = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          // two entries were just removed, so the result always fits
          ram_we         = 1'b1;
          ram_wdata      = alu_rsp.result;
          depth_nxt      = depth_r + DW'(1);
          res_status_nxt = ST_OK;
          res_value_nxt  = alu_rsp.result;
          st_nxt         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // output register: loaded from the pending result, drained by out_ch
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    if (st_r == S_EMIT && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign held_ext = {{ENTRIES_W{1'b0}}, depth_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      kind_r  <= in_ch.kind;
      value_r <= in_ch.operand_value;
    end
    b_r          <= b_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (st_r == S_EMIT && slot_free) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_held_r   <= held_ext[ENTRIES_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.top_value    = out_value_r;
  assign out_ch.entries_held = out_held_r;

  rpn_ram #(
    .WIDTH (XLEN),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (ram_rdata),
    .b     (b_r),
    .rsp   (alu_rsp)
  );

  // depth never runs past the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // the unit only finishes while the sequencer waits for it
  a_alu_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> st_r == S_ALU)
    else $error("arithmetic unit done outside its wait state");

  // a successful push grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXEC && kind_r == KIND_PUSH && !is_full) |=>
      depth_r == $past(depth_r) + DW'(1))
    else $error("push did not grow the stack");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_value_r == '0)
    else $error("error result with nonzero value");

  // a freshly started operation never completes in the next cycle
  a_alu_latency: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |=> !alu_rsp.done)
    else $error("arithmetic unit finished too early");

endmodule

### sim/tb_rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator
// Self-checking bench for the RPN stack evaluator. A shadow stack predicts
// the status, value and depth of every item. The stimulus runs short edge
// cases first, then a burst of pushes drained through random operators and pops past
// empty, then random expressions mixed with noise. Both channels idle at
// random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator import rpn_pkg::*; ();

  localparam int STACK_DEPTH  = 1024;
  localparam int BURST_PUSHES = 16;
  localparam int RANDOM_ITEMS = 390;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 100;   // quiet cycles after the last result

  // kinds the block must ignore
  localparam kind_t KIND_UNUSED_LO = 3'd6;
  localparam kind_t KIND_UNUSED_HI = 3'd7;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7fff_ffff;

  typedef struct packed {
    kind_t kind;
    word_t operand;
  } rpn_item_t;

  typedef struct packed {
    status_t              status;
    word_t                result_val;
    logic [ENTRIES_W-1:0] depth;
  } rpn_answer_t;

  logic clk;
  logic rst_n;

  rpn_in_if  in_ch ();
  rpn_out_if out_ch ();

  rpn_stack_evaluator #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow stack: the expected state of the block, advanced once per accepted
  // input transaction.
  // --------------------------------------------------------------------------
  word_t shadow_stack [STACK_DEPTH];
  int    shadow_depth;

  rpn_item_t   item_feed [$];        // items not yet offered
  rpn_answer_t pending_results [$];  // answers owed by the block, oldest first

  int   mismatch_cnt;
  int   taken_cnt;
  logic in_taken;       // input transaction at the last rising edge
  logic offer_live;     // driver has valid up and not yet accepted
  logic hold_off;       // long receiver stall in progress
  logic send_calm;
  logic recv_calm;
  int   send_gap;
  int   stall_left;

  rpn_item_t   cur_item;
  rpn_answer_t want;

  function automatic rpn_answer_t evaluate_item(kind_t k, word_t operand);
    rpn_answer_t ans;
    word_t       rhs;
    word_t       lhs;
    longint      quo;
    ans.status     = ST_OK;
    ans.result_val = '0;
    case (k) inside
      KIND_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          shadow_stack[shadow_depth] = operand;
          shadow_depth++;
          ans.result_val = operand;
        end
      end
      KIND_POP: begin
        if (shadow_depth == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          shadow_depth--;
          ans.result_val = shadow_stack[shadow_depth];
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        // right operand leaves first and stays gone on any later error
        if (shadow_depth == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          shadow_depth--;
          rhs = shadow_stack[shadow_depth];
          if (k == KIND_DIV && rhs == '0) begin
            ans.status = ST_DIVZERO;
          end else if (shadow_depth == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            shadow_depth--;
            lhs = shadow_stack[shadow_depth];
            case (k)
              KIND_ADD: ans.result_val = lhs + rhs;
              KIND_SUB: ans.result_val = lhs - rhs;
              KIND_MUL: ans.result_val = lhs * rhs;
              default: begin
                // 64-bit quotient: min / -1 wraps back to min when truncated
                quo = longint'(signed'(lhs)) / longint'(signed'(rhs));
                ans.result_val = quo[31:0];
              end
            endcase
            // two entries just left, so this always fits
            shadow_stack[shadow_depth] = ans.result_val;
            shadow_depth++;
          end
        end
      end
      default: ;  // unused kinds: no change, zero value
    endcase
    ans.depth = ENTRIES_W'(shadow_depth);
    return ans;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operands lean on the edges: zero, +/-1, min, max, small values
  function automatic word_t rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5, 6:    return word_t'(int'($urandom_range(0, 32)) - 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_item(kind_t k, word_t operand);
    rpn_item_t it;
    it.kind    = k;
    it.operand = operand;
    item_feed.push_back(it);
  endtask

  task automatic report_mismatch(string what, longint exp_v, longint act_v);
    mismatch_cnt++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next item at the falling edge once the previous one
  // was taken, after a random gap. Calm stretches drop the gaps entirely.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!offer_live || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        offer_live = 1'b0;
        in_ch.valid <= 1'b0;
      end else if (item_feed.size() != 0) begin
        cur_item = item_feed.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= cur_item.kind;
        in_ch.operand_value <= cur_item.operand;
        offer_live = 1'b1;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : idle_len();
      end else begin
        offer_live = 1'b0;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off while hold_off is up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if ($urandom_range(0, 255) == 0) recv_calm = !recv_calm;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every input transaction, then checks every output
  // transaction against the oldest prediction. Input is handled first so a
  // same-edge answer would still find its expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      pending_results.push_back(evaluate_item(in_ch.kind, word_t'(in_ch.operand_value)));
      taken_cnt++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result, status", -1, longint'(out_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", want.status, out_ch.status);
        if (out_ch.top_value !== want.result_val)
          report_mismatch("top_value", longint'(signed'(want.result_val)),
                          longint'(out_ch.top_value));
        if (out_ch.entries_held !== want.depth)
          report_mismatch("entries_held", want.depth, out_ch.entries_held);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Back-pressure: once traffic is flowing, starve the output for a long
  // stretch while the driver keeps offering, so the block stalls its input.
  // --------------------------------------------------------------------------
  initial begin
    hold_off = 1'b0;
    wait (taken_cnt >= 60);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // hard stop in case the block hangs or drops a result
  initial begin
    #10_000_000;
    $display("tb_rpn_stack_evaluator: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int rand_count;
    int pick;
    int operands_left;
    int open_cnt;
    int unsigned k;

    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_PUSH;
    in_ch.operand_value = '0;
    out_ch.ready        = 1'b0;
    rst_n        = 1'b0;
    in_taken     = 1'b0;
    offer_live   = 1'b0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    mismatch_cnt = 0;
    taken_cnt    = 0;
    shadow_depth = 0;

    // -- directed edge cases --
    queue_item(KIND_POP, $urandom());      // pop on empty stack
    queue_item(KIND_ADD, $urandom());      // operator on empty stack
    queue_item(KIND_DIV, $urandom());
    queue_item(KIND_PUSH, word_t'(5));
    queue_item(KIND_SUB, $urandom());      // one entry: consumed, still empty
    queue_item(KIND_PUSH, '0);
    queue_item(KIND_DIV, $urandom());      // zero divisor beats the one-entry case
    queue_item(KIND_PUSH, word_t'(7));
    queue_item(KIND_PUSH, '0);
    queue_item(KIND_DIV, $urandom());      // zero divisor, dividend stays
    queue_item(KIND_POP, $urandom());
    queue_item(KIND_PUSH, WORD_MIN);
    queue_item(KIND_PUSH, '1);
    queue_item(KIND_DIV, $urandom());      // min / -1 wraps
    queue_item(KIND_PUSH, word_t'(1));
    queue_item(KIND_SUB, $urandom());      // min - 1 wraps to max
    queue_item(KIND_PUSH, word_t'(1));
    queue_item(KIND_ADD, $urandom());      // max + 1 wraps to min
    queue_item(KIND_PUSH, WORD_MAX);
    queue_item(KIND_MUL, $urandom());      // product wraps
    queue_item(KIND_PUSH, word_t'(-3));
    queue_item(KIND_DIV, $urandom());      // truncation toward zero
    queue_item(KIND_UNUSED_LO, $urandom());
    queue_item(KIND_UNUSED_HI, '1);
    queue_item(KIND_POP, $urandom());

    // -- burst of pushes, then drain through random operators and pops past empty --
    // Each operator or pop takes exactly one entry off while any are left,
    // so BURST_PUSHES of them empty the stack and the extra ones hit empty.
    for (int i = 0; i < BURST_PUSHES; i++) queue_item(KIND_PUSH, rand_operand());
    for (int i = 0; i < BURST_PUSHES + 3; i++)
      queue_item(kind_t'($urandom_range(KIND_ADD, KIND_POP)), $urandom());

    // -- random: well-formed expressions, some left open, plus noise --
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        operands_left = $urandom_range(1, 5);
        open_cnt      = 0;
        while (operands_left > 0 || open_cnt > 1) begin
          if (open_cnt < 2 || (operands_left > 0 && $urandom_range(0, 1) == 1)) begin
            queue_item(KIND_PUSH, rand_operand());
            operands_left--;
            open_cnt++;
          end else begin
            queue_item(kind_t'($urandom_range(KIND_ADD, KIND_DIV)), $urandom());
            open_cnt--;
          end
          rand_count++;
        end
        // the closing pop is left off now and then, leaving an entry behind
        if (pick >= 8) begin
          queue_item(KIND_POP, $urandom());
          rand_count++;
        end
      end else begin
        k = $urandom_range(KIND_PUSH, KIND_UNUSED_HI);
        queue_item(kind_t'(k), rand_operand());
        if (kind_t'(k) <= KIND_POP) rand_count++;
      end
    end

    // synchronous reset, released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (item_feed.size() != 0 || offer_live) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // anything arriving now is unrequested and gets flagged by the monitor
    repeat (SETTLE) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_rpn_stack_evaluator: done, clean");
    end else begin
      $display("tb_rpn_stack_evaluator: done, errors");
    end
    $finish;
  end

endmodule
